// ===== hw/rtl/dtti_pkg.sv =====
// ----------------------------------------------------------------------------
// dtti_pkg
// shared types and constants for the decimal text to int32 converter
// ----------------------------------------------------------------------------
package dtti_pkg;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam int MagW = 32;
  localparam logic [MagW-1:0] MagCap = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    K_SPACE,
    K_MINUS,
    K_PLUS,
    K_DIGIT,
    K_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    PH_SPACES,
    PH_ZEROS,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

endpackage

// ===== hw/rtl/decimal_text_to_int32_top.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_int32_top
// streaming decimal string to saturated signed 32-bit integer converter
// ----------------------------------------------------------------------------
// throughput: one character per cycle while the queue is not full; the parse step is combinational
// the result registers load when the back end pops the token carrying tlast
// while a result waits, characters keep flowing until the next tlast, then the
// two-entry queue fills and s_tready drops
// reset clears the parse state, the queue and the result valid
// ----------------------------------------------------------------------------
module decimal_text_to_int32_top
  import dtti_pkg::*;
#(
  parameter int MAX_DIGITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // char_code
  input  logic               s_tlast,   // is_last
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [31:0] m_tdata    // value
);

  logic   push;
  token_t push_tok;
  logic   full;
  logic   tok_valid;
  token_t tok;
  logic   pop;

  dtti_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .push     (push),
    .push_tok (push_tok),
    .full     (full)
  );

  dtti_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .full      (full),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (pop)
  );

  dtti_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== hw/rtl/dtti_front.sv =====
// ----------------------------------------------------------------------------
// dtti_front
// classifies each incoming character into a token for the back end
// ----------------------------------------------------------------------------
module dtti_front
  import dtti_pkg::*;
(
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // char_code
  input  logic       s_tlast,   // is_last
  output logic       push,
  output token_t     push_tok,
  input  logic       full
);

  always_comb begin
    push_tok.last  = s_tlast;
    push_tok.digit = 4'(s_tdata - CharZero);
    if (s_tdata == CharSpace) begin
      push_tok.kind = K_SPACE;
    end else if (s_tdata == CharMinus) begin
      push_tok.kind = K_MINUS;
    end else if (s_tdata == CharPlus) begin
      push_tok.kind = K_PLUS;
    end else if (s_tdata >= CharZero && s_tdata <= CharNine) begin
      push_tok.kind = K_DIGIT;
    end else begin
      push_tok.kind = K_OTHER;
    end
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

endmodule

// ===== hw/rtl/dtti_fifo.sv =====
// ----------------------------------------------------------------------------
// dtti_fifo
// two-entry token queue between the front and back ends
// ----------------------------------------------------------------------------
module dtti_fifo
  import dtti_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  output logic   full,
  output logic   tok_valid,
  output token_t tok,
  input  logic   pop
);

  token_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign full      = (count == 2'd2);
  assign tok_valid = (count != 2'd0);
  assign tok       = mem[rd_ptr];

endmodule

// ===== hw/rtl/dtti_back.sv =====
// ----------------------------------------------------------------------------
// dtti_back
// parse state machine, digit accumulation and saturated result register
// ----------------------------------------------------------------------------
module dtti_back
  import dtti_pkg::*;
#(
  parameter int MAX_DIGITS = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  input  token_t             tok,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic signed [31:0] m_tdata
);

  localparam int CntW = $clog2(MAX_DIGITS + 1);

  phase_t          phase, phase_next;
  logic            negative, negative_next;
  logic [MagW-1:0] magnitude, magnitude_next;
  logic [CntW-1:0] digit_count, digit_count_next;
  logic [MagW+3:0] mag_wide;
  logic            taken;
  logic [31:0]     result;

  assign pop = tok_valid && (!tok.last || !m_tvalid || m_tready);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    magnitude_next   = magnitude;
    digit_count_next = digit_count;
    taken            = 1'b0;
    mag_wide = {magnitude, 3'b000} + {3'b000, magnitude, 1'b0} + {{MagW{1'b0}}, tok.digit};
    if (phase_next == PH_SPACES) begin
      if (tok.kind == K_SPACE) begin
        taken = 1'b1;
      end else begin
        phase_next = PH_ZEROS;
        if (tok.kind == K_MINUS) begin
          negative_next = 1'b1;
          taken         = 1'b1;
        end else if (tok.kind == K_PLUS) begin
          taken = 1'b1;
        end
      end
    end
    if (!taken && phase_next == PH_ZEROS) begin
      if (tok.kind == K_DIGIT && tok.digit == 4'd0) begin
        taken = 1'b1;
      end else begin
        phase_next = PH_DIGITS;
      end
    end
    if (!taken && phase_next == PH_DIGITS) begin
      if (tok.kind == K_DIGIT && digit_count < CntW'(MAX_DIGITS)) begin
        magnitude_next   = (mag_wide > {4'b0000, MagCap}) ? MagCap : mag_wide[MagW-1:0];
        digit_count_next = digit_count + CntW'(1);
      end else begin
        phase_next = PH_DONE;
      end
    end
    if (negative_next) begin
      result = 32'(0) - magnitude_next;
    end else begin
      result = (magnitude_next > PosMax) ? PosMax : magnitude_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACES;
      negative    <= 1'b0;
      magnitude   <= '0;
      digit_count <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (pop) begin
        if (tok.last) begin
          phase       <= PH_SPACES;
          negative    <= 1'b0;
          magnitude   <= '0;
          digit_count <= '0;
        end else begin
          phase       <= phase_next;
          negative    <= negative_next;
          magnitude   <= magnitude_next;
          digit_count <= digit_count_next;
        end
      end
      if (pop && tok.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.last) begin
      m_tdata <= result;
    end
  end

endmodule
